[design/pdr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the proximity de-duplicating register.
// No dependencies; every other file of the block uses this package.
package pdr_pkg;

    localparam logic [1:0] CMD_SENSE    = 2'd0;
    localparam logic [1:0] CMD_CHECK    = 2'd1;
    localparam logic [1:0] CMD_REGISTER = 2'd2;

    localparam logic [3:0]  TYPE_NONE  = 4'd0;
    localparam logic [14:0] NEAR_RESET = 15'd320;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               robot;
        logic [3:0]         sensed_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_pdr_in;

    typedef struct packed {
        logic       is_new;
        logic       inserted;
        logic       table_full;
        logic [6:0] entry_count;
    } t_pdr_out;

    typedef struct packed {
        logic [3:0]  etype;
        logic [15:0] x;
        logic [15:0] y;
    } t_pdr_entry;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } t_pdr_cmd;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_pdr_stat;

endpackage

[design/pdr_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences accept, table scan and result write-back.
// Depends on pdr_pkg for the command and status structs.
module pdr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pdr_pkg::t_pdr_stat i_stat,
    output pdr_pkg::t_pdr_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.needs_scan ? ST_SCAN : ST_FIN;
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_stat.pipe_busy && i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/pdr_datapath.sv]
`timescale 1ns / 1ps
// Datapath: item register, robot types, entry memory, distance pipeline, output register.
// Depends on pdr_pkg; driven by pdr_ctrl through a command struct.
module pdr_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdr_pkg::t_pdr_in   i_in,
    input  logic               i_cfg_valid,
    input  logic [14:0]        i_cfg_data,
    input  pdr_pkg::t_pdr_cmd  i_cmd,
    output pdr_pkg::t_pdr_stat o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pdr_pkg::t_pdr_out  o_out
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    pdr_pkg::t_pdr_entry r_mem [TABLE_DEPTH];

    pdr_pkg::t_pdr_in    r_item;
    pdr_pkg::t_pdr_entry r_rd_data;
    logic [3:0]          r_types [2];
    logic [3:0]          r_cur_type;
    logic [14:0]         r_near;
    logic [29:0]         r_r2;
    logic [AW-1:0]       r_idx;
    logic [CW-1:0]       r_count;
    logic                r_rd_vld;
    logic                r_sq_vld;
    logic                r_teq;
    logic [31:0]         r_dx2;
    logic [31:0]         r_dy2;
    logic                r_hit;
    logic                r_out_valid;
    pdr_pkg::t_pdr_out   r_out;

    logic [16:0] w_dx;
    logic [16:0] w_dy;
    logic [16:0] w_adx;
    logic [16:0] w_ady;
    logic [32:0] w_sum;
    logic        w_scan_cmd;
    logic        w_is_new;
    logic        w_room;
    logic        w_insert;
    logic        w_full;
    logic        w_out_free;

    assign w_dx  = {r_rd_data.x[15], r_rd_data.x} - {r_item.pos_x[15], r_item.pos_x};
    assign w_dy  = {r_rd_data.y[15], r_rd_data.y} - {r_item.pos_y[15], r_item.pos_y};
    assign w_adx = w_dx[16] ? (17'd0 - w_dx) : w_dx;
    assign w_ady = w_dy[16] ? (17'd0 - w_dy) : w_dy;
    assign w_sum = {1'b0, r_dx2} + {1'b0, r_dy2};

    assign w_scan_cmd = (r_item.cmd == pdr_pkg::CMD_CHECK) ||
                        (r_item.cmd == pdr_pkg::CMD_REGISTER);
    assign w_is_new   = w_scan_cmd && (r_cur_type != pdr_pkg::TYPE_NONE) && !r_hit;
    assign w_room     = r_count < CW'(TABLE_DEPTH);
    assign w_insert   = (r_item.cmd == pdr_pkg::CMD_REGISTER) && w_is_new && w_room;
    assign w_full     = (r_item.cmd == pdr_pkg::CMD_REGISTER) && w_is_new && !w_room;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_stat.needs_scan = w_scan_cmd && (r_cur_type != pdr_pkg::TYPE_NONE) &&
                               (r_count != '0);
    assign o_stat.scan_last  = (CW'(r_idx) + CW'(1)) == r_count;
    assign o_stat.pipe_busy  = r_rd_vld || r_sq_vld;
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near      <= pdr_pkg::NEAR_RESET;
            r_types[0]  <= pdr_pkg::TYPE_NONE;
            r_types[1]  <= pdr_pkg::TYPE_NONE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_sq_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_near <= i_cfg_data;
            end
            if (i_cmd.load && (i_in.cmd == pdr_pkg::CMD_SENSE)) begin
                r_types[i_in.robot] <= i_in.sensed_type;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + AW'(1);
            end
            r_rd_vld <= i_cmd.issue;
            r_sq_vld <= r_rd_vld;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_sq_vld && r_teq && (w_sum < {3'b000, r_r2})) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.finish && w_insert) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item     <= i_in;
            r_cur_type <= r_types[i_in.robot];
            r_r2       <= {15'd0, r_near} * {15'd0, r_near};
        end
        r_dx2 <= {16'd0, w_adx[15:0]} * {16'd0, w_adx[15:0]};
        r_dy2 <= {16'd0, w_ady[15:0]} * {16'd0, w_ady[15:0]};
        r_teq <= r_rd_data.etype == r_cur_type;
        if (i_cmd.finish) begin
            r_out.is_new      <= w_is_new;
            r_out.inserted    <= w_insert;
            r_out.table_full  <= w_full;
            r_out.entry_count <= 7'(w_insert ? (r_count + CW'(1)) : r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_insert) begin
            r_mem[r_count[AW-1:0]] <= '{etype: r_cur_type,
                                       x:     r_item.pos_x,
                                       y:     r_item.pos_y};
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

endmodule

[design/proximity_dedup_register.sv]
`timescale 1ns / 1ps
// Top level of the proximity de-duplicating register of detected items.
// Depends on pdr_pkg, pdr_ctrl and pdr_datapath.
//
// Channel   Direction  Handshake               Beat payload
// in        input      i_in_valid/o_in_ready   pdr_pkg::t_pdr_in
// out       output     o_out_valid/i_out_ready pdr_pkg::t_pdr_out
// cfg       input      i_cfg_valid/o_cfg_ready near_distance, 15 bits
//
// A sensor report, an unused command, a none type or an empty table skips the table scan.
// A check or register command reads one stored entry per cycle through the single memory
// read port, and its result waits until the scan pipeline has drained.
// Reset is synchronous and needs no clearing pass; the table starts empty.
// A finished result waits in the output register; the next beat is taken meanwhile and
// its own result holds back only until that register is free.
module proximity_dedup_register #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pdr_pkg::t_pdr_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pdr_pkg::t_pdr_out o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [14:0]       i_cfg_data
);

    pdr_pkg::t_pdr_cmd  w_cmd;
    pdr_pkg::t_pdr_stat w_stat;

    assign o_cfg_ready = 1'b1;

    pdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pdr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_valid |=> !o_in_ready)
        else $error("Input accepted a second beat while one was in progress.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.inserted && !o_out.is_new))
        else $error("Entry inserted for an item that was not new.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.table_full |-> o_out.entry_count == 7'(TABLE_DEPTH))
        else $error("Table reported full with room left.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.inserted && o_out.table_full))
        else $error("Inserted and full reported together.");

endmodule
